// File: rtl/swarq_pkg.sv
// ----------------------------------------------------------------------------
// swarq_pkg
// Shared types and constants of the sliding-window ARQ receiver: field widths,
// result kinds, register indexes and the controller/datapath command bundles.
// ----------------------------------------------------------------------------
package swarq_pkg;

  // Fixed field widths
  localparam int SEQ_W     = 32;
  localparam int FLAGS_W   = 8;
  localparam int PAYLOAD_W = 32;
  localparam int KIND_W    = 2;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  // Flag codes
  localparam logic [FLAGS_W-1:0] FLAG_DATA   = 8'd0;
  localparam logic [FLAGS_W-1:0] FLAG_FINISH = 8'd4;

  // Register indexes (paddr[2])
  localparam logic REG_MODE      = 1'b0;
  localparam logic REG_START_SEQ = 1'b1;

  // Mode codes
  localparam logic MODE_GBN = 1'b0;
  localparam logic MODE_SR  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK     = 2'd0,
    KIND_NACK    = 2'd1,
    KIND_DELIVER = 2'd2,
    KIND_FINISH  = 2'd3
  } kind_t;

  // Source of the result sequence number
  typedef enum logic [1:0] {
    SEQ_ITEM   = 2'd0,
    SEQ_NE     = 2'd1,
    SEQ_NE_RUN = 2'd2,
    SEQ_NE_ONE = 2'd3
  } seq_sel_t;

  // Source of the result payload
  typedef enum logic [1:0] {
    PL_ZERO = 2'd0,
    PL_SLOT = 2'd1,
    PL_ITEM = 2'd2
  } pl_sel_t;

  // Controller -> datapath
  typedef struct packed {
    logic     capture;
    logic     push;
    kind_t    kind;
    seq_sel_t seq_sel;
    pl_sel_t  pl_sel;
    logic     last;
    logic     slot_write;
    logic     scan_start;
    logic     scan_step;
    logic     advance;
    logic     cnt_dec;
    logic     set_wait;
    logic     clr_wait;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_free;
    logic crc_ok;
    logic finish;
    logic data;
    logic mode;
    logic seq_match;
    logic waiting;
    logic run_more;
    logic cnt_zero;
    logic cnt_one;
  } sts_t;

endpackage

// File: rtl/swarq_if.sv
// ----------------------------------------------------------------------------
// swarq_if
// Valid/ready channels of the receiver: received packets in, results out.
// ----------------------------------------------------------------------------
interface swarq_pkt_if;
  import swarq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SEQ_W-1:0]     seq;
  logic [FLAGS_W-1:0]   flags;
  logic                 crc_ok;
  logic [PAYLOAD_W-1:0] payload;

  modport source (output valid, seq, flags, crc_ok, payload, input ready);
  modport sink   (input valid, seq, flags, crc_ok, payload, output ready);
endinterface

interface swarq_res_if;
  import swarq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [SEQ_W-1:0]     out_seq;
  logic [PAYLOAD_W-1:0] out_payload;
  logic                 last;

  modport source (output valid, kind, out_seq, out_payload, last, input ready);
  modport sink   (input valid, kind, out_seq, out_payload, last, output ready);
endinterface

// File: rtl/swarq_regs.sv
// ----------------------------------------------------------------------------
// swarq_regs
// APB register file: mode and start_seq. A start_seq write pulses a session
// reload toward the datapath.
// ----------------------------------------------------------------------------
module swarq_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swarq_pkg::ADDR_W-1:0]  paddr,
  input  logic [swarq_pkg::DATA_W-1:0]  pwdata,
  output logic [swarq_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output logic                          mode,
  output logic                          start_load,
  output logic [swarq_pkg::SEQ_W-1:0]   start_seq
);
  import swarq_pkg::*;

  logic wr;
  logic idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_SR;
      start_seq <= '0;
    end else if (wr) begin
      case (idx)
        REG_MODE:      mode      <= pwdata[0];
        REG_START_SEQ: start_seq <= pwdata[SEQ_W-1:0];
        default:       ;
      endcase
    end
  end

  // session reload strobe, in the cycle after the write so start_seq
  // already holds the new value
  always_ff @(posedge clk) begin
    if (rst) begin
      start_load <= 1'b0;
    end else begin
      start_load <= wr && (idx == REG_START_SEQ);
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_MODE:      prdata = DATA_W'(mode);
      REG_START_SEQ: prdata = DATA_W'(start_seq);
      default:       prdata = '0;
    endcase
  end

endmodule

// File: rtl/swarq_dp.sv
// ----------------------------------------------------------------------------
// swarq_dp
// Receiver datapath: captured packet, window slot store, base pointer,
// next expected number, run scan counter and the result output register.
// ----------------------------------------------------------------------------
module swarq_dp #(
  parameter int WINDOW_SLOTS = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             mode,
  input  logic                             start_load,
  input  logic [swarq_pkg::SEQ_W-1:0]      start_seq,
  // packet fields
  input  logic [swarq_pkg::SEQ_W-1:0]      seq,
  input  logic [swarq_pkg::FLAGS_W-1:0]    flags,
  input  logic                             crc_ok,
  input  logic [swarq_pkg::PAYLOAD_W-1:0]  payload,
  // result register
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [swarq_pkg::KIND_W-1:0]     kind,
  output logic [swarq_pkg::SEQ_W-1:0]      out_seq,
  output logic [swarq_pkg::PAYLOAD_W-1:0]  out_payload,
  output logic                             last,
  // controller
  input  swarq_pkg::cmd_t                  cmd,
  output swarq_pkg::sts_t                  sts
);
  import swarq_pkg::*;

  localparam int SW = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
  localparam int BW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int CW = $clog2(WINDOW_SLOTS + 1);

  // captured packet
  logic [SEQ_W-1:0]   item_seq;
  logic [FLAGS_W-1:0] item_flags;
  logic               item_crc;
  logic [SW-1:0]      item_pl;

  // window state
  logic [WINDOW_SLOTS-1:0] slot_valid;
  logic [SW-1:0]           slot_payload [WINDOW_SLOTS];
  logic [SW-1:0]           rd_data;
  logic [BW-1:0]           base;
  logic [BW-1:0]           base_inc;
  logic [BW-1:0]           base_next;
  logic [SEQ_W-1:0]        next_exp;
  logic                    waiting;
  logic [BW-1:0]           ptr;
  logic [CW-1:0]           cnt;

  // window position of the captured packet
  logic [SEQ_W:0]   diff;
  logic             in_win;
  logic [BW:0]      wsum;
  logic [BW-1:0]    widx;
  logic             wr_en;

  // capture the packet
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_seq   <= seq;
      item_flags <= flags;
      item_crc   <= crc_ok;
      item_pl    <= payload[SW-1:0];
    end
  end

  // window check: seq in [next_exp, next_exp + WINDOW_SLOTS)
  assign diff   = {1'b0, item_seq} - {1'b0, next_exp};
  assign in_win = !diff[SEQ_W] && (diff[SEQ_W-1:0] < SEQ_W'(WINDOW_SLOTS));
  assign wsum   = {1'b0, base} + diff[BW:0];
  assign widx   = (wsum >= (BW+1)'(WINDOW_SLOTS)) ?
                  BW'(wsum - (BW+1)'(WINDOW_SLOTS)) : wsum[BW-1:0];
  assign wr_en  = cmd.slot_write && in_win && !slot_valid[widx];

  // base pointer arithmetic
  assign base_inc  = (base == BW'(WINDOW_SLOTS - 1)) ? '0 : base + 1'b1;
  assign base_next = start_load ? '0 : (cmd.advance ? base_inc : base);

  // slot payload memory, read port follows the base
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_payload[widx] <= item_pl;
    end
    rd_data <= slot_payload[base_next];
  end

  // valid bits, base, next expected, resend flag
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      base       <= '0;
      next_exp   <= '0;
      waiting    <= 1'b0;
    end else if (start_load) begin
      slot_valid <= '0;
      base       <= '0;
      next_exp   <= start_seq;
      waiting    <= 1'b0;
    end else begin
      if (wr_en) begin
        slot_valid[widx] <= 1'b1;
      end
      if (cmd.advance) begin
        slot_valid[base] <= 1'b0;
        next_exp         <= next_exp + 1'b1;
      end
      base <= base_next;
      if (cmd.set_wait) begin
        waiting <= 1'b1;
      end else if (cmd.clr_wait) begin
        waiting <= 1'b0;
      end
    end
  end

  // contiguous run scan from the base
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ptr <= '0;
    end else if (cmd.scan_start) begin
      cnt <= '0;
      ptr <= base;
    end else if (cmd.scan_step) begin
      cnt <= cnt + 1'b1;
      ptr <= (ptr == BW'(WINDOW_SLOTS - 1)) ? '0 : ptr + 1'b1;
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - 1'b1;
    end
  end

  // result register
  logic [SEQ_W-1:0]     seq_mux;
  logic [PAYLOAD_W-1:0] pl_mux;

  always_comb begin
    case (cmd.seq_sel)
      SEQ_ITEM:   seq_mux = item_seq;
      SEQ_NE:     seq_mux = next_exp;
      SEQ_NE_RUN: seq_mux = next_exp + SEQ_W'(cnt);
      SEQ_NE_ONE: seq_mux = next_exp + 1'b1;
      default:    seq_mux = item_seq;
    endcase
    case (cmd.pl_sel)
      PL_SLOT: pl_mux = PAYLOAD_W'(rd_data);
      PL_ITEM: pl_mux = PAYLOAD_W'(item_pl);
      default: pl_mux = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      kind        <= cmd.kind;
      out_seq     <= seq_mux;
      out_payload <= pl_mux;
      last        <= cmd.last;
    end
  end

  // status to the controller
  always_comb begin
    sts.out_free  = !out_valid || out_ready;
    sts.crc_ok    = item_crc;
    sts.finish    = (item_flags == FLAG_FINISH);
    sts.data      = (item_flags == FLAG_DATA);
    sts.mode      = mode;
    sts.seq_match = (item_seq == next_exp);
    sts.waiting   = waiting;
    sts.run_more  = (cnt != CW'(WINDOW_SLOTS)) && slot_valid[ptr];
    sts.cnt_zero  = (cnt == '0);
    sts.cnt_one   = (cnt == CW'(1));
  end

  // a pending result is never overwritten
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // run length never exceeds the window
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(WINDOW_SLOTS))
    else $error("run count beyond window");

  // advancing frees the old base slot and steps the expected number
  a_adv_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.advance && !start_load) |=> !slot_valid[$past(base)])
    else $error("base slot still valid after advance");

  a_adv_seq: assert property (@(posedge clk) disable iff (rst)
    (cmd.advance && !start_load) |=> (next_exp == $past(next_exp) + 1'b1))
    else $error("next expected did not step");

endmodule

// File: rtl/swarq_ctrl.sv
// ----------------------------------------------------------------------------
// swarq_ctrl
// Receiver controller: accepts a packet, classifies it, and sequences the
// slot write, run scan, ACK and in-order delivery through the datapath.
// ----------------------------------------------------------------------------
module swarq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output swarq_pkg::cmd_t  cmd,
  input  swarq_pkg::sts_t  sts
);
  import swarq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_DECODE     = 6'b000010,
    S_SCAN       = 6'b000100,
    S_ACK        = 6'b001000,
    S_DELIVER    = 6'b010000,
    S_GB_DELIVER = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end

      S_DECODE: begin
        if (!sts.crc_ok) begin
          if (sts.out_free) begin
            cmd.push    = 1'b1;
            cmd.kind    = KIND_NACK;
            cmd.seq_sel = SEQ_ITEM;
            cmd.pl_sel  = PL_ZERO;
            cmd.last    = 1'b1;
            state_next  = S_IDLE;
          end
        end else if (sts.finish) begin
          if (sts.out_free) begin
            cmd.push    = 1'b1;
            cmd.kind    = KIND_FINISH;
            cmd.seq_sel = SEQ_ITEM;
            cmd.pl_sel  = PL_ZERO;
            cmd.last    = 1'b1;
            state_next  = S_IDLE;
          end
        end else if (!sts.data) begin
          state_next = S_IDLE;
        end else if (sts.mode == MODE_SR) begin
          cmd.slot_write = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else if (sts.seq_match) begin
          if (sts.out_free) begin
            cmd.push    = 1'b1;
            cmd.kind    = KIND_ACK;
            cmd.seq_sel = SEQ_NE_ONE;
            cmd.pl_sel  = PL_ZERO;
            state_next  = S_GB_DELIVER;
          end
        end else if (!sts.waiting) begin
          if (sts.out_free) begin
            cmd.push     = 1'b1;
            cmd.kind     = KIND_ACK;
            cmd.seq_sel  = SEQ_NE;
            cmd.pl_sel   = PL_ZERO;
            cmd.last     = 1'b1;
            cmd.set_wait = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end

      // count the contiguous filled slots, one a cycle
      S_SCAN: begin
        if (sts.run_more) begin
          cmd.scan_step = 1'b1;
        end else begin
          state_next = S_ACK;
        end
      end

      // cumulative ACK
      S_ACK: begin
        if (sts.out_free) begin
          cmd.push    = 1'b1;
          cmd.kind    = KIND_ACK;
          cmd.seq_sel = SEQ_NE_RUN;
          cmd.pl_sel  = PL_ZERO;
          cmd.last    = sts.cnt_zero;
          state_next  = sts.cnt_zero ? S_IDLE : S_DELIVER;
        end
      end

      // drain the run from the base slot
      S_DELIVER: begin
        if (sts.out_free) begin
          cmd.push    = 1'b1;
          cmd.kind    = KIND_DELIVER;
          cmd.seq_sel = SEQ_NE;
          cmd.pl_sel  = PL_SLOT;
          cmd.last    = sts.cnt_one;
          cmd.advance = 1'b1;
          cmd.cnt_dec = 1'b1;
          if (sts.cnt_one) begin
            state_next = S_IDLE;
          end
        end
      end

      // go-back-N delivery of the expected packet
      S_GB_DELIVER: begin
        if (sts.out_free) begin
          cmd.push     = 1'b1;
          cmd.kind     = KIND_DELIVER;
          cmd.seq_sel  = SEQ_ITEM;
          cmd.pl_sel   = PL_ITEM;
          cmd.last     = 1'b1;
          cmd.advance  = 1'b1;
          cmd.clr_wait = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/sliding_window_arq_receiver_core.sv
// ----------------------------------------------------------------------------
// sliding_window_arq_receiver_core
// Receiver side of a selective-repeat / go-back-N ARQ, one packet per item.
// ----------------------------------------------------------------------------
// One packet is taken at a time; pkt.ready is high only while the controller
// is idle. For a selective-repeat packet the controller scans the window one
// slot a cycle to count the run of in-order slots to deliver, issues the
// cumulative ACK, then drains one slot per cycle through the slot memory read
// port while the output register is free. Results leave through a one-entry
// output register, so a stalled result.ready holds the controller where it
// stands. Registers: mode at 0x0 (0 go-back-N, 1 selective repeat), start_seq
// at 0x4; writing start_seq starts a new session on the following cycle and
// must only be done while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_arq_receiver_core #(
  parameter int WINDOW_SLOTS = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  swarq_pkt_if.sink                     pkt,
  swarq_res_if.source                   result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swarq_pkg::ADDR_W-1:0]  paddr,
  input  logic [swarq_pkg::DATA_W-1:0]  pwdata,
  output logic [swarq_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import swarq_pkg::*;

  logic             mode;
  logic             start_load;
  logic [SEQ_W-1:0] start_seq;
  cmd_t             cmd;
  sts_t             sts;

  swarq_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .mode       (mode),
    .start_load (start_load),
    .start_seq  (start_seq)
  );

  swarq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pkt.valid),
    .in_ready (pkt.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  swarq_dp #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .mode        (mode),
    .start_load  (start_load),
    .start_seq   (start_seq),
    .seq         (pkt.seq),
    .flags       (pkt.flags),
    .crc_ok      (pkt.crc_ok),
    .payload     (pkt.payload),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .kind        (result.kind),
    .out_seq     (result.out_seq),
    .out_payload (result.out_payload),
    .last        (result.last),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// File: tb/sliding_window_arq_receiver_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_arq_receiver_core_test
// Self-checking bench for the ARQ receiver: drives packets in bursts, stalls
// the result side on its own pattern, predicts every ACK, NACK, delivery and
// finish result in a window tracker, and checks results in order.
// ----------------------------------------------------------------------------
module sliding_window_arq_receiver_core_test;
  import swarq_pkg::*;

  localparam int WIN          = 8;
  localparam int MAX_RES      = WIN + 1;
  localparam int RANDOM_ITEMS = 86;
  localparam int SETTLE       = 24;
  localparam int CYCLE_LIMIT  = 400000;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int cycle_count  = 0;
  int burst_left   = 0;
  int random_items = 0;

  swarq_pkt_if pkt_bus ();
  swarq_res_if res_bus ();

  sliding_window_arq_receiver_core #(
    .WINDOW_SLOTS(WIN),
    .PAYLOAD_BITS(PAYLOAD_W)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .pkt    (pkt_bus),
    .result (res_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  typedef struct packed {
    kind_t                kind;
    logic [SEQ_W-1:0]     seq;
    logic [PAYLOAD_W-1:0] payload;
    logic                 last;
  } arq_result_t;

  // Window tracker: mirrors receiver state and queues the results each
  // accepted packet must produce.
  class arq_window_tracker;
    logic                 sel_repeat;
    logic [SEQ_W-1:0]     first_seq;
    bit                   slot_full[WIN];
    logic [PAYLOAD_W-1:0] slot_data[WIN];
    int                   base_slot;
    logic [SEQ_W-1:0]     next_exp;
    bit                   resend_wait;
    arq_result_t          pending_results[$];
    arq_result_t          step_res[MAX_RES];
    int                   n_step;
    int                   mismatches;

    function new();
      sel_repeat = MODE_SR;
      first_seq  = '0;
      mismatches = 0;
      open_session();
    endfunction

    function void open_session();
      foreach (slot_full[i]) slot_full[i] = 1'b0;
      base_slot   = 0;
      next_exp    = first_seq;
      resend_wait = 1'b0;
    endfunction

    function void write_reg(logic idx, logic [DATA_W-1:0] value);
      if (idx == REG_MODE) begin
        sel_repeat = value[0];
      end else begin
        first_seq = value;
        open_session();
      end
    endfunction

    function void add(kind_t k, logic [SEQ_W-1:0] s, logic [PAYLOAD_W-1:0] p);
      step_res[n_step] = '{kind: k, seq: s, payload: p, last: 1'b0};
      n_step++;
    endfunction

    // Release the base slot and move the window up by one
    function void advance();
      slot_full[base_slot] = 1'b0;
      base_slot = (base_slot + 1) % WIN;
      next_exp  = next_exp + 1'b1;
    endfunction

    function void note_packet(logic [SEQ_W-1:0] s, logic [FLAGS_W-1:0] f, logic ok,
                              logic [PAYLOAD_W-1:0] p);
      logic [SEQ_W-1:0] offs;
      int               idx;
      int               run;
      arq_result_t      r;
      n_step = 0;
      offs   = s - next_exp;
      if (!ok) begin
        add(KIND_NACK, s, '0);
      end else if (f == FLAG_FINISH) begin
        add(KIND_FINISH, s, '0);
      end else if (f != FLAG_DATA) begin
        n_step = 0;
      end else if (sel_repeat == MODE_SR) begin
        // buffer if inside the window and not yet held
        if (s >= next_exp && offs < WIN) begin
          idx = (base_slot + int'(offs)) % WIN;
          if (!slot_full[idx]) begin
            slot_full[idx] = 1'b1;
            slot_data[idx] = p;
          end
        end
        run = 0;
        idx = base_slot;
        while (run < WIN && slot_full[idx]) begin
          run++;
          idx = (idx + 1) % WIN;
        end
        add(KIND_ACK, next_exp + SEQ_W'(run), '0);
        repeat (run) begin
          add(KIND_DELIVER, next_exp, slot_data[base_slot]);
          advance();
        end
      end else if (s == next_exp) begin
        add(KIND_ACK, next_exp + 1'b1, '0);
        add(KIND_DELIVER, s, p);
        advance();
        resend_wait = 1'b0;
      end else if (!resend_wait) begin
        // single go-back ACK, then silence until the expected packet
        add(KIND_ACK, next_exp, '0);
        resend_wait = 1'b1;
      end
      for (int i = 0; i < n_step; i++) begin
        r      = step_res[i];
        r.last = (i == n_step - 1);
        pending_results.push_back(r);
      end
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [KIND_W-1:0] k, logic [SEQ_W-1:0] s,
                      logic [PAYLOAD_W-1:0] p, logic l);
      arq_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d seq %h", k, s));
        return;
      end
      want = pending_results.pop_front();
      if (k !== want.kind)
        report($sformatf("kind %0d, want %0d (seq %h)", k, want.kind, want.seq));
      if (s !== want.seq)
        report($sformatf("seq %h, want %h (kind %0d)", s, want.seq, want.kind));
      if (p !== want.payload)
        report($sformatf("payload %h, want %h (seq %h)", p, want.payload, want.seq));
      if (l !== want.last)
        report($sformatf("last %b, want %b (seq %h)", l, want.last, want.seq));
    endtask
  endclass

  arq_window_tracker arq = new();

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: ready pattern changes style after each random span
  initial begin
    int style;
    int span;
    style = 0;
    span  = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(8, 40);
      end
      span--;
      case (style)
        0, 1:    res_bus.ready <= 1'b1;
        2:       res_bus.ready <= $urandom_range(0, 1);
        default: res_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready)
      arq.check_result(res_bus.kind, res_bus.out_seq, res_bus.out_payload, res_bus.last);
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Register write: setup cycle, then access until pready
  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    arq.write_reg(idx, value);
  endtask

  // Send one packet; a random gap opens before each new burst
  task automatic send_packet(input logic [SEQ_W-1:0] s, input logic [FLAGS_W-1:0] f,
                             input logic ok, input logic [PAYLOAD_W-1:0] p);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        if (pkt_bus.valid) pkt_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    pkt_bus.valid   <= 1'b1;
    pkt_bus.seq     <= s;
    pkt_bus.flags   <= f;
    pkt_bus.crc_ok  <= ok;
    pkt_bus.payload <= p;
    do @(posedge clk); while (!pkt_bus.ready);
    arq.note_packet(s, f, ok, p);
    burst_left--;
  endtask

  // Hold the sender until every expected result is out and the block settles
  task automatic drain_results();
    if (pkt_bus.valid) pkt_bus.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (arq.pending_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One noise packet: bad CRC, finish, unknown flags, or data below, above or inside the block's range, or at random
  task automatic send_noise(input logic [SEQ_W-1:0] lo, input int k);
    logic [FLAGS_W-1:0] f;
    int                 counted;
    counted = 1;
    case ($urandom_range(0, 6))
      0: send_packet($urandom, FLAGS_W'($urandom), 1'b0, rand_word());
      1: send_packet(rand_word(), FLAG_FINISH, 1'b1, rand_word());
      2: begin
        f = FLAGS_W'($urandom_range(1, 255));
        if (f == FLAG_FINISH) f = ~FLAG_FINISH;
        send_packet($urandom, f, 1'b1, rand_word());
        counted = 0;
      end
      3: send_packet(lo - $urandom_range(1, 4), FLAG_DATA, 1'b1, rand_word());
      4: send_packet(lo + WIN + $urandom_range(0, 3), FLAG_DATA, 1'b1, rand_word());
      5: send_packet(lo + $urandom_range(0, k - 1), FLAG_DATA, 1'b1, rand_word());
      default: send_packet($urandom, FLAG_DATA, 1'b1, rand_word());
    endcase
    random_items += counted;
  endtask

  // A run of consecutive numbers from the window base: shuffled in selective
  // repeat, mostly in order in go-back-N, with noise mixed in
  task automatic run_block();
    logic [SEQ_W-1:0] lo;
    logic [SEQ_W-1:0] order[$];
    logic [SEQ_W-1:0] tmp;
    int               k;
    int               j;
    lo = arq.next_exp;
    k  = $urandom_range(1, WIN);
    for (int i = 0; i < k; i++) order.push_back(lo + i);
    if (arq.sel_repeat == MODE_SR) begin
      for (int i = k - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end else if (k > 1 && $urandom_range(0, 3) == 0) begin
      j            = $urandom_range(0, k - 2);
      tmp          = order[j];
      order[j]     = order[j + 1];
      order[j + 1] = tmp;
    end
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 4) == 0) send_noise(lo, k);
      send_packet(order[i], FLAG_DATA, 1'b1, rand_word());
      random_items++;
    end
  endtask

  // Main sequence
  initial begin
    logic [SEQ_W-1:0] start;
    logic             mode_val;
    int               phase;
    int               phase_goal;
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    pkt_bus.valid   <= 1'b0;
    pkt_bus.seq     <= '0;
    pkt_bus.flags   <= '0;
    pkt_bus.crc_ok  <= 1'b0;
    pkt_bus.payload <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Selective repeat from reset: buffering, duplicate, old, too far,
    // then a full window released at once
    send_packet(32'd0, FLAG_DATA, 1'b1, 32'hFFFF_FFFF);
    send_packet(32'd2, FLAG_DATA, 1'b1, 32'h0);
    send_packet(32'd2, FLAG_DATA, 1'b1, 32'h1234_5678);
    send_packet(32'd9, FLAG_DATA, 1'b1, 32'h0BAD_F00D);
    send_packet(32'd0, FLAG_DATA, 1'b1, 32'h5555_5555);
    for (int s = 3; s <= 8; s++) send_packet(s, FLAG_DATA, 1'b1, rand_word());
    send_packet(32'd1, FLAG_DATA, 1'b1, 32'hA5A5_A5A5);
    // CRC failure wins over flags; unknown flags; finish
    send_packet(32'hFFFF_FFFF, FLAG_FINISH, 1'b0, 32'h0);
    send_packet(32'd10, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    send_packet(32'hFFFF_FFFF, FLAG_FINISH, 1'b1, 32'hFFFF_FFFF);

    // Go-back-N across the sequence wrap, with a go-back and a silent miss
    drain_results();
    write_reg(REG_MODE, DATA_W'(MODE_GBN));
    write_reg(REG_START_SEQ, 32'hFFFF_FFFE);
    send_packet(32'hFFFF_FFFE, FLAG_DATA, 1'b1, 32'h0000_0001);
    send_packet(32'd5, FLAG_DATA, 1'b1, 32'h0000_0002);
    send_packet(32'd6, FLAG_DATA, 1'b1, 32'h0000_0003);
    send_packet(32'hFFFF_FFFF, FLAG_DATA, 1'b1, 32'hFFFF_FFFF);
    send_packet(32'd0, FLAG_DATA, 1'b1, 32'hAAAA_AAAA);

    // Selective repeat across the wrap
    drain_results();
    write_reg(REG_MODE, DATA_W'(MODE_SR));
    write_reg(REG_START_SEQ, 32'hFFFF_FFFD);
    send_packet(32'hFFFF_FFFF, FLAG_DATA, 1'b1, 32'h0F0F_0F0F);
    send_packet(32'hFFFF_FFFD, FLAG_DATA, 1'b1, 32'hF0F0_F0F0);
    send_packet(32'hFFFF_FFFE, FLAG_DATA, 1'b1, 32'h3C3C_3C3C);
    send_packet(32'd0, FLAG_DATA, 1'b1, 32'hC3C3_C3C3);

    // Random phases; some switch mode and keep the session going
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      drain_results();
      if (phase < 2) begin
        mode_val = (phase == 0) ? MODE_GBN : MODE_SR;
        start    = (phase == 0) ? 32'hFFFF_FFFF : 32'h0;
        write_reg(REG_MODE, DATA_W'(mode_val));
        write_reg(REG_START_SEQ, start);
      end else begin
        mode_val = $urandom_range(0, 1);
        write_reg(REG_MODE, DATA_W'(mode_val));
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 2))
            0:       start = 32'hFFFF_FFFF - $urandom_range(0, 12);
            1:       start = $urandom_range(0, 20);
            default: start = $urandom;
          endcase
          write_reg(REG_START_SEQ, start);
        end
      end
      phase_goal = random_items + $urandom_range(15, 25);
      while (random_items < phase_goal && random_items < RANDOM_ITEMS) run_block();
      phase++;
    end

    drain_results();
    if (arq.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
